// ===== rtl/assert_macros.svh =====
// Assertion helpers; empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define AST_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define AST_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define AST_IMPL(label, clk, rst_n, ante, cons)
`define AST_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/eckf_pkg.sv =====
package eckf_pkg;
    localparam int MAP_SIDE = 256;
    localparam int SIDE_W = $clog2(MAP_SIDE);
    localparam int IDX_W = 2 * SIDE_W;
    localparam int CELLS = MAP_SIDE * MAP_SIDE;

    typedef enum logic [2:0] {
        OC_OUTSIDE = 3'd0,
        OC_INIT    = 3'd1,
        OC_IGNORE  = 3'd2,
        OC_RAISE   = 3'd3,
        OC_INFLATE = 3'd4,
        OC_FUSE    = 3'd5
    } outcome_t;

    typedef enum logic [2:0] {
        REG_GATE    = 3'd0,
        REG_WINDOW  = 3'd1,
        REG_ALPHA   = 3'd2,
        REG_NOISE   = 3'd3,
        REG_FLOOR   = 3'd4,
        REG_CEILING = 3'd5
    } reg_idx_t;

    // one cell as held in memory
    typedef struct packed {
        logic        valid;
        logic        time_known;
        logic [31:0] height;
        logic [31:0] var_q;
        logic [23:0] color;
        logic [31:0] scan_time;
        logic [31:0] wall_time;
    } cell_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] low;
        logic [31:0] sx;
        logic [31:0] sy;
        logic [31:0] sz;
    } lowest_t;

    // long-op unit control
    typedef struct packed {
        logic        start;
        logic        is_sqrt;
        logic [63:0] num;
        logic [32:0] den;
    } divreq_t;

    typedef struct packed {
        logic        done;
        logic [63:0] quo;
    } divrsp_t;

    function automatic logic [31:0] clamp_var(input logic [33:0] v,
                                              input logic [31:0] lo,
                                              input logic [31:0] hi);
        logic [31:0] r;
        if (v < {2'b0, lo}) r = lo;
        else if (v > {2'b0, hi}) r = hi;
        else r = v[31:0];
        return r;
    endfunction
endpackage

// ===== rtl/eckf_divsqrt.sv =====
// Restoring divider (64/33) and integer square root (64 bit), one bit per cycle.
module eckf_divsqrt (
    input  logic            clk,
    input  logic            rst_n,
    input  eckf_pkg::divreq_t req,
    output eckf_pkg::divrsp_t rsp
);
    import eckf_pkg::*;

    logic        busy_reg, busy_next;
    logic        sq_reg, sq_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [63:0] num_reg, num_next;
    logic [32:0] den_reg, den_next;
    logic [65:0] rem_reg, rem_next;
    logic [63:0] quo_reg, quo_next;
    logic        done_reg, done_next;
    logic [65:0] trial;
    logic [65:0] rem_sh;

    always_comb
    begin
        busy_next = busy_reg;
        sq_next   = sq_reg;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        done_next = 1'b0;
        trial     = '0;
        rem_sh    = '0;
        if (req.start)
        begin
            busy_next = 1'b1;
            sq_next   = req.is_sqrt;
            num_next  = req.num;
            den_next  = req.den;
            rem_next  = '0;
            quo_next  = '0;
            cnt_next  = sq_next ? 7'd32 : 7'd64;
        end
        else if (busy_reg)
        begin
            if (sq_reg)
            begin
                // two bits of radicand per step
                rem_sh   = {rem_reg[63:0], num_reg[63:62]};
                trial    = {quo_reg[63:0], 2'b01};
                num_next = {num_reg[61:0], 2'b00};
                if (rem_sh >= trial)
                begin
                    rem_next = rem_sh - trial;
                    quo_next = {quo_reg[62:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh;
                    quo_next = {quo_reg[62:0], 1'b0};
                end
            end
            else
            begin
                rem_sh   = {rem_reg[64:0], num_reg[63]};
                trial    = {33'b0, den_reg};
                num_next = {num_reg[62:0], 1'b0};
                if (rem_sh >= trial)
                begin
                    rem_next = rem_sh - trial;
                    quo_next = {quo_reg[62:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh;
                    quo_next = {quo_reg[62:0], 1'b0};
                end
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sq_reg  <= sq_next;
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;
endmodule

// ===== rtl/eckf_cell_mem.sv =====
// Cell store: cell words and lowest-point records, with registered read data.
// Valid bits live in separate memories that are swept clear after reset.
module eckf_cell_mem (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [eckf_pkg::IDX_W-1:0]    rd_addr,
    output eckf_pkg::cell_t               rd_cell,
    output eckf_pkg::lowest_t             rd_low,
    input  logic                          wr_cell_en,
    input  logic                          wr_low_en,
    input  logic [eckf_pkg::IDX_W-1:0]    wr_addr,
    input  eckf_pkg::cell_t               wr_cell,
    input  eckf_pkg::lowest_t             wr_low,
    output logic                          clear_busy
);
    import eckf_pkg::*;

    logic [$bits(cell_t)-3:0]   data_mem [CELLS];
    logic [1:0]                 flag_mem [CELLS];
    logic [127:0]               low_mem  [CELLS];
    logic                       lflag_mem [CELLS];
    logic [$bits(cell_t)-3:0]   data_q;
    logic [1:0]                 flag_q;
    logic [127:0]               low_q;
    logic                       lflag_q;
    logic [IDX_W:0]             clr_reg, clr_next;

    assign clear_busy = !clr_reg[IDX_W];
    assign clr_next   = clear_busy ? clr_reg + 1'b1 : clr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_reg <= '0;
        else
            clr_reg <= clr_next;
    end

    always_ff @(posedge clk)
    begin
        if (clear_busy)
        begin
            flag_mem[clr_reg[IDX_W-1:0]]  <= 2'b00;
            lflag_mem[clr_reg[IDX_W-1:0]] <= 1'b0;
        end
        else
        begin
            if (wr_cell_en)
                flag_mem[wr_addr] <= {wr_cell.valid, wr_cell.time_known};
            if (wr_low_en)
                lflag_mem[wr_addr] <= wr_low.valid;
        end
        if (wr_cell_en)
            data_mem[wr_addr] <= wr_cell[$bits(cell_t)-3:0];
        if (wr_low_en)
            low_mem[wr_addr] <= {wr_low.low, wr_low.sx, wr_low.sy, wr_low.sz};
        data_q  <= data_mem[rd_addr];
        flag_q  <= flag_mem[rd_addr];
        low_q   <= low_mem[rd_addr];
        lflag_q <= lflag_mem[rd_addr];
    end

    assign rd_cell = {flag_q, data_q};
    assign rd_low  = {lflag_q, low_q};
endmodule

// ===== rtl/elevation_cell_kalman_update.sv =====
// Elevation cell Kalman update. One point per item; one result per item.
// From the input transfer, a point outside the map goes straight to DONE;
// an initialization runs READ, EVAL, WRITE, DONE; a point the gate ignores,
// raises or inflates runs READ, EVAL, PREP, GATE, WRITE, DONE; a fusion adds
// SQRT, DIV1 and DIV2 after GATE on the shared bit-serial unit: a 32-step
// square root, then one 64-step divide (height gain) and a second (variance);
// when both variances are zero the divides are skipped. PREP forms the square
// of the height difference and the gate product in two 32x32 halves.
// The input stall drops in the cycle the result appears, so the next point
// can transfer in that same cycle. Cell state sits in synchronous memories
// whose read is issued at the input transfer; one point is worked at a time,
// so no forwarding is needed. After reset a clearing pass over all
// MAP_SIDE*MAP_SIDE cells (65536) resets the valid flags; no point is taken
// during it, configuration writes are taken always. The result sits in an
// output register; the next point is taken while it waits for transfer.
module elevation_cell_kalman_update (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [23:0] point_x,
    input  logic signed [23:0] point_y,
    input  logic signed [31:0] point_height,
    input  logic [31:0]        point_var,
    input  logic [23:0]        point_rgb,
    input  logic [31:0]        scan_time,
    input  logic [31:0]        wall_time,
    input  logic signed [31:0] sensor_x,
    input  logic signed [31:0] sensor_y,
    input  logic signed [31:0] sensor_z,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         outcome,
    output logic signed [31:0] new_height,
    output logic [31:0]        new_var,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);
    import eckf_pkg::*;
    `include "assert_macros.svh"

    typedef enum logic [3:0] {
        S_IDLE, S_READ, S_EVAL, S_PREP, S_GATE, S_SQRT, S_DIV1, S_DIV2, S_WRITE, S_DONE
    } state_t;

    state_t      state_reg, state_next;

    // configuration
    logic [31:0] gate_reg, window_reg, noise_reg, floor_reg, ceil_reg;
    logic [16:0] alpha_reg;

    // captured point
    logic signed [31:0] z_reg;
    logic [31:0]        pv_reg, st_reg, wt_reg, sx_reg, sy_reg, sz_reg;
    logic [23:0]        rgb_reg;
    logic [IDX_W-1:0]   idx_reg;

    // working registers
    cell_t       cell_reg;
    lowest_t     low_reg;
    logic [31:0] d_reg;
    logic        up_reg;
    logic [63:0] lhs_reg, t2_reg;
    logic [63:0] rlo_reg, rhi_reg;
    logic [31:0] q_reg;
    logic [2:0]  oc_reg;
    logic        wr_cell_reg, wr_low_reg;

    // output register
    logic        ov_reg;
    logic [2:0]  oc_out_reg;
    logic [31:0] h_out_reg, v_out_reg;

    cell_t       rd_cell;
    lowest_t     rd_low;
    logic        clear_busy;
    divreq_t     dreq;
    divrsp_t     drsp;

    logic        accept;
    logic        outside;
    logic [IDX_W-1:0] idx_calc;

    logic signed [32:0] diff;
    logic [63:0]  dsq;
    logic [95:0]  rhs;
    logic         outlier;
    logic signed [32:0] dt;
    logic         same;
    logic [16:0]  a_sat;
    logic signed [50:0] hb;
    logic signed [50:0] hr;
    logic [50:0]  vb;
    logic signed [34:0] low_c;
    logic signed [31:0] low_sat;
    logic [32:0]  den;
    logic [31:0]  hnew;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE) || clear_busy;
    assign cfg_ready = 1'b1;

    assign outside  = point_x[23] || point_y[23] ||
                      (point_x[22:8] >= 15'(MAP_SIDE)) || (point_y[22:8] >= 15'(MAP_SIDE));
    assign idx_calc = {point_y[8 +: SIDE_W], point_x[8 +: SIDE_W]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gate_reg   <= 32'd655360;
            window_reg <= 32'd100;
            alpha_reg  <= 17'd32768;
            noise_reg  <= 32'd1638400;
            floor_reg  <= 32'd327680;
            ceil_reg   <= 32'd6553600;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_GATE:    gate_reg   <= cfg_data;
                REG_WINDOW:  window_reg <= cfg_data;
                REG_ALPHA:   alpha_reg  <= cfg_data[16:0];
                REG_NOISE:   noise_reg  <= cfg_data;
                REG_FLOOR:   floor_reg  <= cfg_data;
                REG_CEILING: ceil_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    eckf_cell_mem u_mem (
        .clk        (clk),
        .rst_n      (rst_n),
        .rd_addr    (accept ? idx_calc : idx_reg),
        .rd_cell    (rd_cell),
        .rd_low     (rd_low),
        .wr_cell_en (state_reg == S_WRITE && wr_cell_reg),
        .wr_low_en  (state_reg == S_WRITE && wr_low_reg),
        .wr_addr    (idx_reg),
        .wr_cell    (cell_reg),
        .wr_low     (low_reg),
        .clear_busy (clear_busy)
    );

    eckf_divsqrt u_div (
        .clk (clk),
        .rst_n (rst_n),
        .req (dreq),
        .rsp (drsp)
    );

    // h - z straight from the memory word, registered as |z-h| in S_EVAL
    assign diff    = {rd_cell.height[31], rd_cell.height} - {z_reg[31], z_reg};
    assign dsq     = 64'(d_reg) * 64'(d_reg);
    // gate product t2 * var, assembled from the two halves taken in S_PREP
    assign rhs     = {rhi_reg, 32'b0} + 96'(rlo_reg);
    assign outlier = {lhs_reg, 16'b0} > rhs;
    assign dt      = $signed({1'b0, st_reg}) - $signed({1'b0, cell_reg.scan_time});
    assign same    = cell_reg.time_known && (dt <= $signed({1'b0, window_reg}));
    assign a_sat   = alpha_reg[16] ? 17'd65536 : alpha_reg;
    assign hb      = $signed({1'b0, a_sat}) * $signed(cell_reg.height)
                   + $signed(18'(17'd65536 - a_sat)) * z_reg + 51'sd32768;
    assign hr      = hb >>> 16;
    assign vb      = 51'(a_sat) * 51'(cell_reg.var_q)
                   + 51'(17'd65536 - a_sat) * 51'(pv_reg) + 51'd32768;
    // lowest candidate from the finished root, valid while drsp.done is high
    assign low_c   = 35'(z_reg) + 35'(drsp.quo[31:0]) * 35'd3;
    assign low_sat = (low_c > 35'sd2147483647) ? 32'sh7fffffff : low_c[31:0];
    assign den     = {1'b0, cell_reg.var_q} + {1'b0, pv_reg};
    assign hnew    = up_reg ? cell_reg.height - q_reg : cell_reg.height + q_reg;

    always_comb
    begin
        dreq = '0;
        unique case (state_reg)
            S_GATE:
            begin
                if (!outlier)
                begin
                    dreq.start   = 1'b1;
                    dreq.is_sqrt = 1'b1;
                    dreq.num     = {16'b0, pv_reg, 16'b0};
                end
            end
            S_SQRT:
            begin
                if (drsp.done && den != 33'd0)
                begin
                    dreq.start = 1'b1;
                    dreq.num   = 64'(cell_reg.var_q) * 64'(d_reg) + 64'(den[32:1]);
                    dreq.den   = den;
                end
            end
            S_DIV1:
            begin
                if (drsp.done)
                begin
                    dreq.start = 1'b1;
                    dreq.num   = 64'(cell_reg.var_q) * 64'(pv_reg) + 64'(den[32:1]);
                    dreq.den   = den;
                end
            end
            default: ;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (accept) state_next = outside ? S_DONE : S_READ;
            S_READ:  state_next = S_EVAL;
            S_EVAL:  state_next = rd_cell.valid ? S_PREP : S_WRITE;
            S_PREP:  state_next = S_GATE;
            S_GATE:  state_next = outlier ? S_WRITE : S_SQRT;
            S_SQRT:  if (drsp.done) state_next = (den == 33'd0) ? S_WRITE : S_DIV1;
            S_DIV1:  if (drsp.done) state_next = S_DIV2;
            S_DIV2:  if (drsp.done) state_next = S_WRITE;
            S_WRITE: state_next = S_DONE;
            S_DONE:  if (!ov_reg || !out_stall) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_DONE && state_next == S_IDLE)
                ov_reg <= 1'b1;
            else if (!out_stall)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_DONE && state_next == S_IDLE)
        begin
            oc_out_reg <= oc_reg;
            h_out_reg  <= (oc_reg == OC_OUTSIDE) ? 32'd0 : cell_reg.height;
            v_out_reg  <= (oc_reg == OC_OUTSIDE) ? 32'd0 : cell_reg.var_q;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    z_reg   <= point_height;
                    pv_reg  <= point_var;
                    rgb_reg <= point_rgb;
                    st_reg  <= scan_time;
                    wt_reg  <= wall_time;
                    sx_reg  <= sensor_x;
                    sy_reg  <= sensor_y;
                    sz_reg  <= sensor_z;
                    idx_reg <= idx_calc;
                    oc_reg  <= OC_OUTSIDE;
                    wr_cell_reg <= 1'b0;
                    wr_low_reg  <= 1'b0;
                end
            end
            S_READ: ;
            S_EVAL:
            begin
                low_reg  <= rd_low;
                t2_reg   <= 64'(gate_reg) * 64'(gate_reg);
                // gate operands: |z-h| and which way the cell moves
                d_reg    <= diff[32] ? 32'(-diff) : diff[31:0];
                up_reg   <= !diff[32] && (diff != 33'sd0);
                if (!rd_cell.valid)
                begin
                    cell_reg    <= {1'b1, rd_cell.time_known, z_reg,
                                    clamp_var({2'b0, pv_reg}, floor_reg, ceil_reg),
                                    rgb_reg, rd_cell.scan_time, rd_cell.wall_time};
                    oc_reg      <= OC_INIT;
                    wr_cell_reg <= 1'b1;
                end
                else
                    cell_reg <= rd_cell;
            end
            S_PREP:
            begin
                lhs_reg <= dsq;
                rlo_reg <= 64'(t2_reg[31:0]) * 64'(cell_reg.var_q);
                rhi_reg <= 64'(t2_reg[63:32]) * 64'(cell_reg.var_q);
            end
            S_GATE:
            begin
                if (outlier)
                begin
                    if (same && $signed(cell_reg.height) > z_reg)
                        oc_reg <= OC_IGNORE;
                    else if (same)
                    begin
                        cell_reg.height <= hr[31:0];
                        cell_reg.var_q  <= clamp_var({1'b0, vb[48:16]}, floor_reg, ceil_reg);
                        oc_reg      <= OC_RAISE;
                        wr_cell_reg <= 1'b1;
                    end
                    else
                    begin
                        cell_reg.var_q <= clamp_var(34'(cell_reg.var_q) + 34'(noise_reg),
                                                    floor_reg, ceil_reg);
                        oc_reg      <= OC_INFLATE;
                        wr_cell_reg <= 1'b1;
                    end
                end
            end
            S_SQRT:
            begin
                if (drsp.done)
                begin
                    if (!low_reg.valid || low_sat < $signed(low_reg.low))
                        wr_low_reg <= 1'b1;
                    low_reg <= (!low_reg.valid || low_sat < $signed(low_reg.low)) ?
                               {1'b1, low_sat, sx_reg, sy_reg, sz_reg} : low_reg;
                    if (den == 33'd0)
                    begin
                        cell_reg.var_q <= clamp_var(34'd0, floor_reg, ceil_reg);
                        cell_reg.color <= rgb_reg;
                        cell_reg.scan_time  <= st_reg;
                        cell_reg.wall_time  <= wt_reg;
                        cell_reg.time_known <= 1'b1;
                        oc_reg      <= OC_FUSE;
                        wr_cell_reg <= 1'b1;
                    end
                end
            end
            S_DIV1:
                if (drsp.done) q_reg <= drsp.quo[31:0];
            S_DIV2:
            begin
                if (drsp.done)
                begin
                    cell_reg.height <= hnew;
                    cell_reg.var_q  <= clamp_var({2'b0, drsp.quo[31:0]}, floor_reg, ceil_reg);
                    cell_reg.color  <= rgb_reg;
                    cell_reg.scan_time  <= st_reg;
                    cell_reg.wall_time  <= wt_reg;
                    cell_reg.time_known <= 1'b1;
                    oc_reg      <= OC_FUSE;
                    wr_cell_reg <= 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign out_valid  = ov_reg;
    assign outcome    = oc_out_reg;
    assign new_height = h_out_reg;
    assign new_var    = v_out_reg;

    `AST_IMPL(a_no_accept_in_clear, clk, rst_n, clear_busy, !accept)
    `AST_NEXT(a_write_then_done, clk, rst_n, state_reg == S_WRITE, state_reg == S_DONE)
    `AST_IMPL(a_out_outcome_range, clk, rst_n, out_valid, outcome <= OC_FUSE)
endmodule

// ===== dv/testbench.sv =====
module testbench;
    import eckf_pkg::*;

    // Indexes past the register list; writes there must change nothing.
    localparam logic [2:0] REG_SPARE_A = 3'd6;
    localparam logic [2:0] REG_SPARE_B = 3'd7;

    // One measured point as driven on the input channel.
    typedef struct {
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic signed [31:0] z;
        logic [31:0]        pvar;
        logic [23:0]        rgb;
        logic [31:0]        scan;
        logic [31:0]        wall;
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic signed [31:0] sz;
    } point_t;

    typedef struct {
        outcome_t           oc;
        logic signed [31:0] h;
        logic [31:0]        v;
    } cell_result_t;

    // Height-fusion predictor and the queue of cell results it expects.
    class height_scoreboard;
        bit [31:0] gate_thr, window, alpha, noise, vfloor, vceil;
        bit        cell_ok[CELLS];
        bit        time_ok[CELLS];
        bit [31:0] cell_h[CELLS];
        bit [31:0] cell_v[CELLS];
        bit [31:0] cell_scan[CELLS];
        cell_result_t expected_q[$];
        int errors;
        int seen[6];

        function new();
            gate_thr = 655360;
            window   = 100;
            alpha    = 32768;
            noise    = 1638400;
            vfloor   = 327680;
            vceil    = 6553600;
            errors   = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] data);
            case (idx)
                REG_GATE:    gate_thr = data;
                REG_WINDOW:  window   = data;
                REG_ALPHA:   alpha    = data & 32'h1FFFF;
                REG_NOISE:   noise    = data;
                REG_FLOOR:   vfloor   = data;
                REG_CEILING: vceil    = data;
                default: ;
            endcase
        endfunction

        function bit [31:0] clampv(longint unsigned v);
            if (v < vfloor) return vfloor;
            if (v > vceil) return vceil;
            return v[31:0];
        endfunction

        function longint unsigned floor_sqrt(longint unsigned n);
            longint unsigned res, probe;
            res = 0;
            probe = 64'd1 << 62;
            while (probe > n) probe >>= 2;
            while (probe != 0)
            begin
                if (n >= res + probe)
                begin
                    n -= res + probe;
                    res = (res >> 1) + probe;
                end
                else
                    res >>= 1;
                probe >>= 2;
            end
            return res;
        endfunction

        function void note_point(point_t p);
            cell_result_t r;
            longint signed xs, ys, z, h, dt, a, s;
            longint unsigned pv, v, d, den, q;
            logic [127:0] lhs, rhs;
            int idx;
            bit outl, same;
            xs = p.x;
            ys = p.y;
            r.oc = OC_OUTSIDE;
            r.h = 0;
            r.v = 0;
            if (xs >= 0 && ys >= 0 && (xs >> 8) < MAP_SIDE && (ys >> 8) < MAP_SIDE)
            begin
                idx = int'((ys >> 8) * MAP_SIDE + (xs >> 8));
                z = p.z;
                pv = p.pvar;
                if (!cell_ok[idx])
                begin
                    cell_ok[idx] = 1;
                    cell_h[idx] = p.z;
                    cell_v[idx] = clampv(pv);
                    r.oc = OC_INIT;
                end
                else
                begin
                    h = $signed(cell_h[idx]);
                    v = cell_v[idx];
                    d = (z >= h) ? z - h : h - z;
                    lhs = (128'(d) * d) << 16;
                    rhs = 128'(gate_thr) * gate_thr * v;
                    outl = lhs > rhs;
                    if (outl)
                    begin
                        same = 0;
                        if (time_ok[idx])
                        begin
                            dt = longint'(p.scan) - longint'(cell_scan[idx]);
                            same = dt <= longint'(window);
                        end
                        if (same && h > z)
                            r.oc = OC_IGNORE;
                        else if (same)
                        begin
                            a = (alpha > 65536) ? 65536 : alpha;
                            s = a * h + (65536 - a) * z + 32768;
                            cell_h[idx] = s >>> 16;
                            cell_v[idx] = clampv((a * v + (65536 - a) * pv + 32768) >> 16);
                            r.oc = OC_RAISE;
                        end
                        else
                        begin
                            cell_v[idx] = clampv(v + noise);
                            r.oc = OC_INFLATE;
                        end
                    end
                    else
                    begin
                        // lowest-point record is not visible on the result port
                        den = v + pv;
                        if (den == 0)
                            cell_v[idx] = clampv(0);
                        else
                        begin
                            q = (v * d + den / 2) / den;
                            cell_h[idx] = (z >= h) ? h + q : h - q;
                            cell_v[idx] = clampv((v * pv + den / 2) / den);
                        end
                        cell_scan[idx] = p.scan;
                        time_ok[idx] = 1;
                        r.oc = OC_FUSE;
                    end
                end
                r.h = cell_h[idx];
                r.v = cell_v[idx];
            end
            seen[r.oc]++;
            expected_q = {expected_q, r};
        endfunction

        function void check_result(logic [2:0] oc, logic signed [31:0] h, logic [31:0] v);
            cell_result_t e;
            if (expected_q.size() == 0)
            begin
                $display("%0t: result with nothing expected: outcome %0d height %0d var %0d",
                         $time, oc, h, v);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (oc !== e.oc)
            begin
                $display("%0t: outcome expected %0d actual %0d", $time, e.oc, oc);
                errors++;
            end
            if (h !== e.h)
            begin
                $display("%0t: new_height expected %0d actual %0d", $time, e.h, h);
                errors++;
            end
            if (v !== e.v)
            begin
                $display("%0t: new_var expected %0d actual %0d", $time, e.v, v);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic signed [23:0] point_x;
    logic signed [23:0] point_y;
    logic signed [31:0] point_height;
    logic [31:0]        point_var;
    logic [23:0]        point_rgb;
    logic [31:0]        scan_time;
    logic [31:0]        wall_time;
    logic signed [31:0] sensor_x;
    logic signed [31:0] sensor_y;
    logic signed [31:0] sensor_z;
    logic               out_valid;
    logic               out_stall;
    logic [2:0]         outcome;
    logic signed [31:0] new_height;
    logic [31:0]        new_var;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [2:0]         cfg_index;
    logic [31:0]        cfg_data;

    height_scoreboard sb;
    int send_idle_pct;     // chance of a gap before each input transfer
    int recv_stall_pct;    // chance of stall in each cycle
    int hold_len;          // long receiver hold-off, counted down below
    int point_total;
    bit [31:0] scan_clock; // advancing scan time so same-scan cases occur

    elevation_cell_kalman_update dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .point_x(point_x), .point_y(point_y), .point_height(point_height),
        .point_var(point_var), .point_rgb(point_rgb), .scan_time(scan_time),
        .wall_time(wall_time), .sensor_x(sensor_x), .sensor_y(sensor_y),
        .sensor_z(sensor_z),
        .out_valid(out_valid), .out_stall(out_stall), .outcome(outcome),
        .new_height(new_height), .new_var(new_var),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Result side: check each transfer, then pick the stall for the next cycle.
    // A pending hold-off overrides the random stall so the block backs up.
    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
            sb.check_result(outcome, new_height, new_var);
        if (hold_len > 0)
        begin
            out_stall <= 1'b1;
            hold_len--;
        end
        else
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    // Register write; after the transfer it drops cfg_valid and waits for the next
    // edge before returning, so back-to-back calls never assign cfg_valid twice in one step.
    task automatic write_cfg(input logic [2:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(idx, data);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_all(input logic [31:0] g, input logic [31:0] w, input logic [31:0] a,
                             input logic [31:0] n, input logic [31:0] f, input logic [31:0] c);
        write_cfg(REG_GATE, g);
        write_cfg(REG_WINDOW, w);
        write_cfg(REG_ALPHA, a);
        write_cfg(REG_NOISE, n);
        write_cfg(REG_FLOOR, f);
        write_cfg(REG_CEILING, c);
    endtask

    task automatic drive_point(input point_t p);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        point_x      <= p.x;
        point_y      <= p.y;
        point_height <= p.z;
        point_var    <= p.pvar;
        point_rgb    <= p.rgb;
        scan_time    <= p.scan;
        wall_time    <= p.wall;
        sensor_x     <= p.sx;
        sensor_y     <= p.sy;
        sensor_z     <= p.sz;
        do @(posedge clk); while (in_stall);
        sb.note_point(p);
        point_total++;
    endtask

    // Sender pause: wait for every result, then hold the input idle before returning.
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (150) @(posedge clk);
    endtask

    function automatic point_t mk(int x, int y, int z, bit [31:0] pv, bit [31:0] sc);
        point_t p;
        p.x = x;
        p.y = y;
        p.z = z;
        p.pvar = pv;
        p.rgb = $urandom;
        p.scan = sc;
        p.wall = $urandom;
        p.sx = $urandom;
        p.sy = $urandom;
        p.sz = $urandom;
        return p;
    endfunction

    // Mostly a handful of cells hit repeatedly, heights close enough for the
    // gate to go both ways; some far cells and some fully random points.
    function automatic point_t rand_point();
        point_t p;
        int sel;
        sel = $urandom_range(0, 99);
        if ($urandom_range(0, 19) == 0)
            scan_clock += $urandom_range(0, 2000);
        else
            scan_clock += $urandom_range(0, 60);
        if (sel < 10)
        begin
            p = mk($urandom, $urandom, $urandom, $urandom, $urandom);
        end
        else
        begin
            p = mk(0, 0, $urandom_range(0, 40 * 65536) - 20 * 65536,
                   $urandom_range(0, 50 * 65536), scan_clock);
            if (sel < 20)
            begin
                p.x = $urandom_range(0, 65535);
                p.y = $urandom_range(0, 65535);
            end
            else
            begin
                p.x = $urandom_range(0, 3) * 256 + $urandom_range(0, 255);
                p.y = $urandom_range(0, 1) * 256 + $urandom_range(0, 255);
            end
            if ($urandom_range(0, 19) == 0)
                p.pvar = 0;
            if ($urandom_range(0, 29) == 0)
                p.z = $urandom;
        end
        return p;
    endfunction

    task automatic random_run(input int count);
        for (int i = 0; i < count; i++)
        begin
            if (i == count / 3)
                hold_len = 400;       // receiver backs off, sender keeps offering
            if (i == 2 * count / 3)
                drain();
            drive_point(rand_point());
        end
        drain();
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        point_x = '0;
        point_y = '0;
        point_height = '0;
        point_var = '0;
        point_rgb = '0;
        scan_time = '0;
        wall_time = '0;
        sensor_x = '0;
        sensor_y = '0;
        sensor_z = '0;
        send_idle_pct = 25;
        recv_stall_pct = 64;
        hold_len = 0;
        point_total = 0;
        scan_clock = 1000;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: map edges, every outcome, extreme heights and variances.
        write_all(655360, 100, 32768, 1638400, 327680, 6553600);
        drive_point(mk(-1, 0, 0, 65536, 0));
        drive_point(mk(0, -8388608, 0, 65536, 0));
        drive_point(mk(65536, 0, 0, 65536, 0));
        drive_point(mk(0, 8388607, 0, 65536, 0));
        drive_point(mk(8388607, 65535, 0, 65536, 0));
        drive_point(mk(0, 0, 0, 4 * 65536, 10));            // init, var below floor
        drive_point(mk(255, 255, 65536, 65536, 10));        // fuse
        drive_point(mk(10, 20, 200 * 65536, 65536, 20));    // same scan, higher: raise
        drive_point(mk(10, 20, -200 * 65536, 65536, 30));   // same scan, lower: ignore
        drive_point(mk(10, 20, -200 * 65536, 65536, 500));  // older scan: inflate
        drive_point(mk(65535, 65535, 32'h7FFFFFFF, 32'hFFFFFFFF, 0));
        drive_point(mk(65535, 65535, 32'h80000000, 0, 0));  // time unknown: inflate
        drive_point(mk(65535, 65535, 32'h7FFFFFFF, 32'hFFFFFFFF, 5));
        drive_point(mk(65535, 65535, 32'h7FFFFFF0, 32'hFFFFFFFF, 6));
        drive_point(mk(65280, 0, 32'h80000000, 0, 32'hFFFFFFFF));
        drive_point(mk(65280, 0, 32'h80000000, 65536, 0));
        drive_point(mk(0, 65280, -5, 32'hFFFFFFFF, 0));
        drive_point(mk(0, 65280, 5, 32'hFFFFFFFF, 1));
        drain();
        random_run(280);

        // Permissive extremes: zero gate, floor zero so zero variance occurs.
        write_all(0, 32'hFFFFFFFF, 65536, 32'hFFFFFFFF, 0, 32'hFFFFFFFF);
        write_cfg(REG_SPARE_A, 32'h12345678);
        write_cfg(REG_SPARE_B, 32'hFFFFFFFF);
        send_idle_pct = 64;
        recv_stall_pct = 25;
        drive_point(mk(100 * 256, 100 * 256, 777, 0, 0));   // init at zero variance
        drive_point(mk(100 * 256, 100 * 256, 777, 0, 3));   // both variances zero
        drive_point(mk(100 * 256, 100 * 256, 778, 0, 4));   // zero variance gates
        drain();
        random_run(260);

        // Other extremes: huge gate, zero window and alpha, floor above ceiling.
        send_idle_pct = 0;
        recv_stall_pct = 0;
        write_all(32'hFFFFFFFF, 0, 0, 0, 32'hFFFFFFFF, 0);
        random_run(60);

        // Moderate random settings, no idling.
        write_all($urandom_range(65536, 20 * 65536), $urandom_range(0, 300),
                  $urandom_range(0, 65536), $urandom, $urandom_range(0, 10 * 65536),
                  $urandom_range(50 * 65536, 32'hFFFFFFFF));
        random_run(230);

        $display("Sent %0d points: outside %0d, init %0d, ignore %0d, raise %0d,",
                 point_total, sb.seen[0], sb.seen[1], sb.seen[2], sb.seen[3]);
        $display("inflate %0d, fuse %0d, over four register settings", sb.seen[4], sb.seen[5]);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Run limit: clearing pass plus slow fused points under heavy stalling.
    initial
    begin
        #30000000;
        $display("Mismatches found");
        $finish;
    end
endmodule
